### rtl/timed_relay_controller_top_defines.svh
// assertion macros for the timed relay controller
`ifndef TIMED_RELAY_CONTROLLER_TOP_DEFINES_SVH
`define TIMED_RELAY_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trc check failed");

// next-cycle implication, checked out of reset
`define TRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trc check failed");

`endif

### rtl/trc_pkg.sv
package trc_pkg;

    localparam int TIME_W  = 32;
    localparam int NUM_W   = 39;
    localparam int PCT_W   = 7;
    localparam int OUT_PCT_W = 8;
    localparam int CMD_W   = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_POLL   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STATUS = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOUT_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_INVERTED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ON       = 3'd4;

    localparam logic [TIME_W-1:0]    REPORT_INTERVAL_RST = 32'd1000;
    localparam logic [PCT_W-1:0]     PCT_MAX  = 7'd100;
    localparam logic [OUT_PCT_W-1:0] PCT_IDLE = 8'hFF;

    typedef struct packed {
        logic [TIME_W-1:0] default_duration;
        logic [TIME_W-1:0] holdout_duration;
        logic [TIME_W-1:0] report_interval;
        logic              drive_inverted;
        logic              initial_on;
        logic              preset_load;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [TIME_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] pct;
    } div_rsp_t;

endpackage

### rtl/timed_relay_controller_top.sv
// Timed relay controller. Each item is a command and gives exactly one result item.
// A poll advances the millisecond clock by one, handles the trigger and unlock
// buttons, ends an expired run and decides whether a status report is due; the other
// commands act on the run and lock state without advancing the clock. The run
// progress in percent is found by a 39-step serial divider, which is only used
// when a run is still active after the command. A result still waiting on the
// output holds the sequencer in its last step. A new item is taken once the
// previous one has left the sequencer, even while its result still waits on the
// output.
// Configuration writes are taken at any time but must only be issued while idle;
// writing initial_on also loads the relay state.
`include "timed_relay_controller_top_defines.svh"

module timed_relay_controller_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [trc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [trc_pkg::TIME_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [trc_pkg::CMD_W-1:0]              command,
    input  logic [trc_pkg::TIME_W-1:0]             run_length,
    input  logic                                   use_default,
    input  logic                                   has_length,
    input  logic                                   force_req,
    input  logic                                   trigger_press,
    input  logic                                   unlock_press,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   relay_drive,
    output logic signed [trc_pkg::OUT_PCT_W-1:0]   covered_percent,
    output logic                                   is_locked,
    output logic                                   report_due,
    output logic                                   syntax_error
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK   = 3'd1;
    localparam logic [2:0] S_CMD    = 3'd2;
    localparam logic [2:0] S_EXPIRE = 3'd3;
    localparam logic [2:0] S_BASE   = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    trc_pkg::cfg_t     cfg;
    trc_pkg::div_req_t div_req;
    trc_pkg::div_rsp_t div_rsp;

    logic [2:0] state_reg, state_next;

    logic [trc_pkg::TIME_W-1:0] clock_reg, clock_next;
    logic [trc_pkg::TIME_W-1:0] held_len_reg, held_len_next;
    logic [trc_pkg::TIME_W-1:0] stop_time_reg, stop_time_next;
    logic [trc_pkg::TIME_W-1:0] last_report_reg, last_report_next;
    logic [trc_pkg::TIME_W-1:0] holdout_end_reg, holdout_end_next;
    logic                       lock_reg, lock_next;
    logic                       pending_reg, pending_next;
    logic                       relay_on_reg, relay_on_next;

    logic [trc_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [trc_pkg::TIME_W-1:0] len_reg, len_next;
    logic                       use_def_reg, use_def_next;
    logic                       has_len_reg, has_len_next;
    logic                       force_reg, force_next;
    logic                       trig_reg, trig_next;
    logic                       unl_reg, unl_next;
    logic [trc_pkg::TIME_W-1:0] elapsed_reg, elapsed_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           relay_drive_reg, relay_drive_next;
    logic [trc_pkg::OUT_PCT_W-1:0]  pct_out_reg, pct_out_next;
    logic                           locked_out_reg, locked_out_next;
    logic                           due_out_reg, due_out_next;
    logic                           err_out_reg, err_out_next;

    logic                       is_poll;
    logic                       is_bad;
    logic [trc_pkg::TIME_W-1:0] start_len;
    logic                       start_ok;
    logic                       do_start;
    logic                       do_stop;
    logic                       pct_pos;
    logic                       due;
    logic [trc_pkg::NUM_W-1:0]  elapsed_w;

    trc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign is_poll   = (cmd_reg == trc_pkg::CMD_POLL);
    assign is_bad    = (cmd_reg > trc_pkg::CMD_STATUS);
    assign start_len = (is_poll || use_def_reg) ? cfg.default_duration : len_reg;
    assign start_ok  = (clock_reg >= holdout_end_reg) && (!lock_reg || (!is_poll && force_reg));
    assign elapsed_w = {{(trc_pkg::NUM_W-trc_pkg::TIME_W){1'b0}}, elapsed_reg};

    // elapsed * 100 as shift-add into the divider
    always_comb
    begin
        div_req.start = (state_reg == S_MUL);
        div_req.num   = (elapsed_w << 6) + (elapsed_w << 5) + (elapsed_w << 2);
        div_req.den   = held_len_reg;
    end

    always_comb
    begin
        do_start = 1'b0;
        do_stop  = 1'b0;
        if (is_poll)
        begin
            do_start = trig_reg && (held_len_reg == '0);
            do_stop  = trig_reg && (held_len_reg != '0);
        end
        else
        begin
            do_start = (cmd_reg == trc_pkg::CMD_START) && has_len_reg;
            do_stop  = (cmd_reg == trc_pkg::CMD_STOP);
        end
    end

    always_comb
    begin
        pct_pos = (held_len_reg != '0) && (div_rsp.pct != '0);
        due     = is_poll &&
                  (pending_reg ||
                   (pct_pos && (last_report_reg != '0) &&
                    ((clock_reg - last_report_reg) > cfg.report_interval)) ||
                   ((held_len_reg == '0) && (last_report_reg < stop_time_reg)));
    end

    always_comb
    begin
        state_next       = state_reg;
        clock_next       = clock_reg;
        held_len_next    = held_len_reg;
        stop_time_next   = stop_time_reg;
        last_report_next = last_report_reg;
        holdout_end_next = holdout_end_reg;
        lock_next        = lock_reg;
        pending_next     = pending_reg;
        relay_on_next    = relay_on_reg;
        cmd_next         = cmd_reg;
        len_next         = len_reg;
        use_def_next     = use_def_reg;
        has_len_next     = has_len_reg;
        force_next       = force_reg;
        trig_next        = trig_reg;
        unl_next         = unl_reg;
        elapsed_next     = elapsed_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        relay_drive_next = relay_drive_reg;
        pct_out_next     = pct_out_reg;
        locked_out_next  = locked_out_reg;
        due_out_next     = due_out_reg;
        err_out_next     = err_out_reg;

        if (cfg.preset_load)
        begin
            relay_on_next = cfg.initial_on;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = command;
                    len_next     = run_length;
                    use_def_next = use_default;
                    has_len_next = has_length;
                    force_next   = force_req;
                    trig_next    = trigger_press;
                    unl_next     = unlock_press;
                    state_next   = (command == trc_pkg::CMD_POLL) ? S_TICK : S_CMD;
                end
            end
            S_TICK:
            begin
                clock_next = clock_reg + 32'd1;
                state_next = S_CMD;
            end
            S_CMD:
            begin
                if (do_start && start_ok)
                begin
                    relay_on_next  = 1'b1;
                    held_len_next  = start_len;
                    stop_time_next = clock_reg + start_len;
                    pending_next   = 1'b1;
                end
                if (do_stop)
                begin
                    relay_on_next    = 1'b0;
                    stop_time_next   = clock_reg;
                    holdout_end_next = clock_reg + cfg.holdout_duration;
                    held_len_next    = '0;
                    pending_next     = 1'b1;
                end
                unique case (cmd_reg)
                    trc_pkg::CMD_POLL:
                    begin
                        if (unl_reg)
                        begin
                            lock_next    = 1'b0;
                            pending_next = 1'b1;
                        end
                    end
                    trc_pkg::CMD_LOCK:   lock_next = 1'b1;
                    trc_pkg::CMD_UNLOCK: lock_next = 1'b0;
                    default: ;
                endcase
                if (!is_poll)
                begin
                    pending_next = 1'b1;
                end
                state_next = is_poll ? S_EXPIRE : S_BASE;
            end
            S_EXPIRE:
            begin
                // run ends once the clock passes the stop time
                if ((held_len_reg != '0) && (stop_time_reg != '0) &&
                    (clock_reg > stop_time_reg))
                begin
                    relay_on_next    = 1'b0;
                    stop_time_next   = clock_reg;
                    holdout_end_next = clock_reg + cfg.holdout_duration;
                    held_len_next    = '0;
                    pending_next     = 1'b1;
                end
                state_next = S_BASE;
            end
            S_BASE:
            begin
                elapsed_next = clock_reg - stop_time_reg + held_len_reg;
                state_next   = (held_len_reg == '0) ? S_FIN : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (due)
                    begin
                        last_report_next = clock_reg;
                        pending_next     = 1'b0;
                    end
                    out_valid_next   = 1'b1;
                    relay_drive_next = relay_on_reg ^ cfg.drive_inverted;
                    pct_out_next     = (held_len_reg == '0) ? trc_pkg::PCT_IDLE
                                                            : {1'b0, div_rsp.pct};
                    locked_out_next  = lock_reg;
                    due_out_next     = due;
                    err_out_next     = is_bad;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            clock_reg       <= '0;
            held_len_reg    <= '0;
            stop_time_reg   <= '0;
            last_report_reg <= '0;
            holdout_end_reg <= '0;
            lock_reg        <= 1'b0;
            pending_reg     <= 1'b0;
            relay_on_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clock_reg       <= clock_next;
            held_len_reg    <= held_len_next;
            stop_time_reg   <= stop_time_next;
            last_report_reg <= last_report_next;
            holdout_end_reg <= holdout_end_next;
            lock_reg        <= lock_next;
            pending_reg     <= pending_next;
            relay_on_reg    <= relay_on_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        len_reg         <= len_next;
        use_def_reg     <= use_def_next;
        has_len_reg     <= has_len_next;
        force_reg       <= force_next;
        trig_reg        <= trig_next;
        unl_reg         <= unl_next;
        elapsed_reg     <= elapsed_next;
        relay_drive_reg <= relay_drive_next;
        pct_out_reg     <= pct_out_next;
        locked_out_reg  <= locked_out_next;
        due_out_reg     <= due_out_next;
        err_out_reg     <= err_out_next;
    end

    assign out_valid       = out_valid_reg;
    assign relay_drive     = relay_drive_reg;
    assign covered_percent = pct_out_reg;
    assign is_locked       = locked_out_reg;
    assign report_due      = due_out_reg;
    assign syntax_error    = err_out_reg;

    `TRC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `TRC_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_reg == S_DIV)
    `TRC_ASSERT_NOW(a_pct_range, out_valid_reg,
        (pct_out_reg == trc_pkg::PCT_IDLE) || (pct_out_reg <= 8'd100))
    `TRC_ASSERT_NOW(a_div_only_running, div_req.start, held_len_reg != '0)

endmodule

### rtl/trc_cfg.sv
module trc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [trc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [trc_pkg::TIME_W-1:0]        cfg_data,
    output trc_pkg::cfg_t                     cfg
);

    logic [trc_pkg::TIME_W-1:0] default_duration_reg;
    logic [trc_pkg::TIME_W-1:0] holdout_duration_reg;
    logic [trc_pkg::TIME_W-1:0] report_interval_reg;
    logic                       drive_inverted_reg;
    logic                       wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_duration_reg <= '0;
            holdout_duration_reg <= '0;
            report_interval_reg  <= trc_pkg::REPORT_INTERVAL_RST;
            drive_inverted_reg   <= 1'b0;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                trc_pkg::REG_DEFAULT_DURATION: default_duration_reg <= cfg_data;
                trc_pkg::REG_HOLDOUT_DURATION: holdout_duration_reg <= cfg_data;
                trc_pkg::REG_REPORT_INTERVAL:  report_interval_reg  <= cfg_data;
                trc_pkg::REG_DRIVE_INVERTED:   drive_inverted_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // initial_on acts only as a preset of the relay state when written
    always_comb
    begin
        cfg.default_duration = default_duration_reg;
        cfg.holdout_duration = holdout_duration_reg;
        cfg.report_interval  = report_interval_reg;
        cfg.drive_inverted   = drive_inverted_reg;
        cfg.initial_on       = cfg_data[0];
        cfg.preset_load      = wr && (cfg_index == trc_pkg::REG_INITIAL_ON);
    end

endmodule

### rtl/trc_div.sv
module trc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  trc_pkg::div_req_t   req,
    output trc_pkg::div_rsp_t   rsp
);

    localparam int CNT_W = $clog2(trc_pkg::NUM_W + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(trc_pkg::NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    logic [trc_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [trc_pkg::TIME_W-1:0] rem_reg, rem_next;
    logic [trc_pkg::TIME_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [trc_pkg::TIME_W:0]   trial;
    logic [trc_pkg::TIME_W:0]   diff;
    logic                       qbit;

    // one restoring step per cycle, quotient shifts into the numerator register
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[trc_pkg::NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        qbit      = !diff[trc_pkg::TIME_W];
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CNT_LOAD;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? diff[trc_pkg::TIME_W-1:0] : trial[trc_pkg::TIME_W-1:0];
            quo_next  = {quo_reg[trc_pkg::NUM_W-2:0], qbit};
            cnt_next  = cnt_reg - CNT_LAST;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // saturate at full scale
    always_comb
    begin
        rsp.done = done_reg;
        if ((quo_reg[trc_pkg::NUM_W-1:trc_pkg::PCT_W] != '0) ||
            (quo_reg[trc_pkg::PCT_W-1:0] > trc_pkg::PCT_MAX))
        begin
            rsp.pct = trc_pkg::PCT_MAX;
        end
        else
        begin
            rsp.pct = quo_reg[trc_pkg::PCT_W-1:0];
        end
    end

endmodule
